>>> hdl/bcu_pkg.sv
// shared types and constants for the binomial coefficient unit
`timescale 1ns / 1ps
package bcu_pkg;
	localparam int VALUE_WIDTH = 64;
	localparam int CNT_WIDTH = $clog2(VALUE_WIDTH + 1);

	typedef struct packed {
		logic start;
		logic [VALUE_WIDTH-1:0] dividend;
		logic [VALUE_WIDTH-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	typedef enum logic [3:0] {
		S_IDLE, S_INIT, S_CHK, S_GCD, S_GCDW, S_DENW, S_FACW, S_ACCW, S_MULW, S_OUT
	} seq_state_t;
endpackage

>>> hdl/bcu_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module bcu_div (
	input  logic clk,
	input  logic arst_n,
	input  bcu_pkg::div_req_t req,
	output bcu_pkg::unit_stat_t stat,
	output logic [bcu_pkg::VALUE_WIDTH-1:0] quot,
	output logic [bcu_pkg::VALUE_WIDTH-1:0] rem
);
	import bcu_pkg::*;

	logic [VALUE_WIDTH:0] rem_q;
	logic [VALUE_WIDTH-1:0] q_q, d_q;
	logic [CNT_WIDTH-1:0] cnt_q;
	logic busy_q, done_q;
	logic [VALUE_WIDTH:0] shifted, diff;

	assign shifted = {rem_q[VALUE_WIDTH-1:0], q_q[VALUE_WIDTH-1]};
	assign diff = shifted - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_WIDTH'(VALUE_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_WIDTH'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			q_q <= req.dividend;
			d_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[VALUE_WIDTH]) begin
				rem_q <= diff;
				q_q <= {q_q[VALUE_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				q_q <= {q_q[VALUE_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot = q_q;
	assign rem = rem_q[VALUE_WIDTH-1:0];
endmodule

>>> hdl/bcu_mul.sv
// shift-add multiplier with sticky range check, one multiplier bit per cycle
`timescale 1ns / 1ps
module bcu_mul (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [bcu_pkg::VALUE_WIDTH-1:0] a,
	input  logic [bcu_pkg::VALUE_WIDTH-1:0] b,
	output bcu_pkg::unit_stat_t stat,
	output logic [bcu_pkg::VALUE_WIDTH-1:0] product,
	output logic ovf
);
	import bcu_pkg::*;

	logic [VALUE_WIDTH-1:0] p_q, a_q, b_q;
	logic ovf_q, busy_q, done_q;
	logic [CNT_WIDTH-1:0] cnt_q;
	logic [VALUE_WIDTH+1:0] sum;

	// msb first: double then add
	assign sum = {1'b0, p_q, 1'b0}
		+ (b_q[VALUE_WIDTH-1] ? {2'b00, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_WIDTH'(VALUE_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_WIDTH'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			p_q <= '0;
			a_q <= a;
			b_q <= b;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			p_q <= sum[VALUE_WIDTH-1:0];
			b_q <= {b_q[VALUE_WIDTH-2:0], 1'b0};
			if (sum[VALUE_WIDTH+1:VALUE_WIDTH] != 2'b00)
				ovf_q <= 1'b1;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign product = p_q;
	assign ovf = ovf_q;
endmodule

>>> hdl/binomial_coefficient_unit.sv
// binomial coefficient unit: sequencer over a shared divider and a serial multiplier
//
// channel  dir  tdata                      tuser
// s_axis   in   [63:0] n_value [127:64] k_value  -
// m_axis   out  [63:0] coefficient         [0] overflow
//
// each term takes a euclid loop of divides (one to eight of them), two more
// divides, an acc / g divide and a multiply; up to about 34 terms per item
// the shared divider sets the pace; one item is in flight at a time
// s_tready is high only when the sequencer is idle; a finished result waits
// in the output register while the next item is taken
// arst_n clears the sequencer and the output valid
`timescale 1ns / 1ps
module binomial_coefficient_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [2*bcu_pkg::VALUE_WIDTH-1:0] s_tdata, // n_value, k_value
	output logic m_tvalid,
	input  logic m_tready,
	output logic [bcu_pkg::VALUE_WIDTH-1:0] m_tdata, // coefficient
	output logic m_tuser // overflow
);
	import bcu_pkg::*;

	localparam logic [VALUE_WIDTH-1:0] ALL_ONES = '1;
	localparam logic [VALUE_WIDTH-1:0] ONE = VALUE_WIDTH'(1);

	seq_state_t state_q, state_d;
	logic [VALUE_WIDTH-1:0] n_q, k_q, acc_q, step_q, a_q, b_q, g_q, fac_q, res_q;
	logic ovf_res_q;
	logic out_valid_q;
	logic [VALUE_WIDTH-1:0] out_data_q;
	logic out_ovf_q;

	div_req_t div_req;
	unit_stat_t div_stat, mul_stat;
	logic [VALUE_WIDTH-1:0] quot, rem, product;
	logic mul_start, mul_ovf, out_free;

	bcu_div u_div (
		.clk(clk), .arst_n(arst_n), .req(div_req), .stat(div_stat),
		.quot(quot), .rem(rem)
	);

	bcu_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(quot), .b(fac_q),
		.stat(mul_stat), .product(product), .ovf(mul_ovf)
	);

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		div_req.start = 1'b0;
		div_req.dividend = a_q;
		div_req.divisor = b_q;
		mul_start = 1'b0;
		unique case (state_q)
			S_IDLE: if (s_tvalid) state_d = S_INIT;
			S_INIT: state_d = (k_q > n_q) ? S_OUT : S_CHK;
			S_CHK: state_d = (step_q > k_q) ? S_OUT : S_GCD;
			S_GCD: begin
				div_req.start = 1'b1;
				if (b_q == '0) begin
					// gcd found in a_q, start step / g
					div_req.dividend = step_q;
					div_req.divisor = a_q;
					state_d = S_DENW;
				end else begin
					state_d = S_GCDW;
				end
			end
			S_GCDW: if (div_stat.done) state_d = S_GCD;
			S_DENW: begin
				div_req.dividend = n_q - step_q + ONE;
				div_req.divisor = quot;
				if (div_stat.done) begin
					div_req.start = 1'b1;
					state_d = S_FACW;
				end
			end
			S_FACW: begin
				div_req.dividend = acc_q;
				div_req.divisor = g_q;
				if (div_stat.done) begin
					div_req.start = 1'b1;
					state_d = S_ACCW;
				end
			end
			S_ACCW: if (div_stat.done) begin
				mul_start = 1'b1;
				state_d = S_MULW;
			end
			S_MULW: if (mul_stat.done) state_d = mul_ovf ? S_OUT : S_CHK;
			S_OUT: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (s_tvalid) begin
				n_q <= s_tdata[VALUE_WIDTH-1:0];
				k_q <= s_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH];
			end
			S_INIT: begin
				acc_q <= ONE;
				step_q <= ONE;
				ovf_res_q <= 1'b0;
				res_q <= '0;
				if (k_q > n_q - k_q) k_q <= n_q - k_q;
			end
			S_CHK: begin
				res_q <= acc_q;
				a_q <= acc_q;
				b_q <= step_q;
			end
			S_GCD: if (b_q == '0) g_q <= a_q;
			S_GCDW: if (div_stat.done) begin
				a_q <= b_q;
				b_q <= rem;
			end
			S_FACW: if (div_stat.done) fac_q <= quot;
			S_MULW: if (mul_stat.done) begin
				if (mul_ovf) begin
					ovf_res_q <= 1'b1;
					res_q <= ALL_ONES;
				end else begin
					acc_q <= product;
					step_q <= step_q + ONE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == S_OUT && out_free)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			out_data_q <= res_q;
			out_ovf_q <= ovf_res_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_ovf_q;

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(div_stat.busy && mul_stat.busy)) else $error("divider and multiplier both busy");
	a_idle_units: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !div_stat.busy && !mul_stat.busy) else $error("unit busy while idle");
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == ALL_ONES) else $error("overflow without saturation");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT && out_free |=> m_tvalid) else $error("result not presented");
endmodule
